// File: rtl/three_level_priority_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-level priority queue
// Shared property wrappers, clocked on clk and quiet while rst is high.
// ----------------------------------------------------------------------------
`ifndef THREE_LEVEL_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define THREE_LEVEL_PRIORITY_QUEUE_CORE_DEFINES_SVH

// same-cycle implication
`define TLPQ_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tlpq_pkg.sv
// ----------------------------------------------------------------------------
// tlpq_pkg
// Sizes, codes and shared types of the three-level priority queue.
// ----------------------------------------------------------------------------
package tlpq_pkg;

  localparam int CAPACITY     = 16;
  localparam int ARRIVAL_BITS = 16;
  localparam int PRIO_W       = 2;
  localparam int KEY_W        = 16;
  localparam int CNT_OUT_W    = 5;
  localparam int OCC_W        = $clog2(CAPACITY + 1);
  localparam int CMP_W        = (ARRIVAL_BITS > KEY_W) ? ARRIVAL_BITS : KEY_W;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 40;

  localparam logic [ARRIVAL_BITS-1:0] ARR_MAX = '1;
  localparam logic [PRIO_W-1:0]       PRIO_RED    = 2'd1;
  localparam logic [PRIO_W-1:0]       PRIO_YELLOW = 2'd2;
  localparam logic [PRIO_W-1:0]       PRIO_GREEN  = 2'd3;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } q_state_t;

  typedef struct packed {
    logic                    valid;
    logic [PRIO_W-1:0]       prio;
    logic [ARRIVAL_BITS-1:0] arr;
  } entry_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t                op;
    logic [PRIO_W-1:0]       prio;
    logic [KEY_W-1:0]        key;
    logic [ARRIVAL_BITS-1:0] arr_new;
  } cell_ctrl_t;

endpackage

// File: rtl/tlpq_cell.sv
// ----------------------------------------------------------------------------
// tlpq_cell
// One slot of the sorted row: holds an entry and shifts with its neighbors.
// ----------------------------------------------------------------------------
module tlpq_cell import tlpq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     left_entry,
  input  logic       left_gt,
  input  entry_t     right_entry,
  input  logic       hit_in,
  output entry_t     entry,
  output logic       gt,
  output logic       hit_out
);

  logic                    valid;
  logic [PRIO_W-1:0]       prio;
  logic [ARRIVAL_BITS-1:0] arr;
  entry_t                  entry_next;
  logic                    match;

  assign entry = '{valid: valid, prio: prio, arr: arr};

  // slot sorts after the new entry (empty slots sort last)
  assign gt      = !valid || (prio > ctrl.prio);
  assign match   = valid && (prio == ctrl.prio) && (CMP_W'(arr) == CMP_W'(ctrl.key));
  assign hit_out = hit_in || match;

  always_comb begin
    entry_next = entry;
    case (ctrl.op)
      CELL_INSERT: begin
        if (gt) begin
          entry_next = left_gt ? left_entry
                               : entry_t'{valid: 1'b1, prio: ctrl.prio, arr: ctrl.arr_new};
        end
      end
      CELL_REMOVE: begin
        if (hit_out) begin
          entry_next = right_entry;
        end
      end
      CELL_ROTATE: entry_next = right_entry;
      default:     entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= entry_next.valid;
    end
    prio <= entry_next.prio;
    arr  <= entry_next.arr;
  end

endmodule

// File: rtl/three_level_priority_queue_core.sv
// An insert or remove answers in the cycle after its beat is taken.
// A new insert or remove is taken once the last result beat is taken; a dump holds
// the input for one full turn of the cell ring plus any output stall.
// A dump of an empty queue answers with a single invalid beat.
// Reset (rst, synchronous) empties all cells, zeroes the arrival counter and
// occupancy counts and drops any pending output beat; no clearing pass.
// ----------------------------------------------------------------------------
// three_level_priority_queue_core
// Stable three-level priority queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
`include "three_level_priority_queue_core_defines.svh"

module three_level_priority_queue_core import tlpq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // input beat
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // command[1:0], priority_req[3:2], position[19:4]
  // result beat
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // status[1:0], entry_priority[3:2],
                                           // entry_position[19:4], count_red[24:20],
                                           // count_yellow[29:25], count_green[34:30]
  output logic                   m_tuser,  // entry_valid
  output logic                   m_tlast   // last
);

  // --------------------------------------------------------------------------
  // Input decode
  // --------------------------------------------------------------------------
  cmd_t              cmd;
  logic [PRIO_W-1:0] prio_req;
  logic [KEY_W-1:0]  key;
  logic [PRIO_W-1:0] prio_ins;   // priority zero saturates to red on insert
  logic [PRIO_W-1:0] prio_cell;
  logic              accept;

  assign cmd      = cmd_t'(s_tdata[1:0]);
  assign prio_req = s_tdata[3:2];
  assign key      = s_tdata[19:4];
  assign prio_ins = (prio_req == '0) ? PRIO_RED : prio_req;
  // a remove keeps priority zero so that it never matches a held entry
  assign prio_cell = (cmd == CMD_INSERT) ? prio_ins : prio_req;
  assign accept    = s_tvalid && s_tready;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  q_state_t                state, state_next;
  logic [ARRIVAL_BITS-1:0] arr_ctr, arr_ctr_next;
  logic [OCC_W-1:0]        occ, occ_next;
  logic [OCC_W-1:0]        cnt [3];
  logic [OCC_W-1:0]        cnt_next [3];
  logic [OCC_W-1:0]        rot, rot_next;   // ring steps taken during a dump
  cell_op_t                cell_op;
  cell_ctrl_t              ctrl;

  // output beat staging
  logic                    load;
  status_t                 res_status_next;
  logic                    res_valid_next;
  logic [PRIO_W-1:0]       res_prio_next;
  logic [KEY_W-1:0]        res_pos_next;
  logic                    res_last_next;
  status_t                 res_status;
  logic                    res_valid;
  logic [PRIO_W-1:0]       res_prio;
  logic [KEY_W-1:0]        res_pos;
  logic                    res_last;
  logic [CNT_OUT_W-1:0]    res_cnt [3];
  logic                    out_free;

  // --------------------------------------------------------------------------
  // Cell row: cell 0 is the head of the queue
  // --------------------------------------------------------------------------
  entry_t                entry_w [CAPACITY];
  logic                  gt_w    [CAPACITY];
  logic                  hit_w   [CAPACITY];
  logic [CAPACITY-1:0]   valid_vec;

  assign ctrl = '{op: cell_op, prio: prio_cell, key: key, arr_new: arr_ctr + 1'b1};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_g, hit_i;

    if (i == 0) begin : g_head
      assign left_e = '0;
      assign left_g = 1'b0;
      assign hit_i  = 1'b0;
    end else begin : g_body
      assign left_e = entry_w[i-1];
      assign left_g = gt_w[i-1];
      assign hit_i  = hit_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      // tail closes the ring while dumping, otherwise pulls in an empty slot
      assign right_e = (cell_op == CELL_ROTATE) ? entry_w[0] : '0;
    end else begin : g_inner
      assign right_e = entry_w[i+1];
    end

    tlpq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .right_entry (right_e),
      .hit_in      (hit_i),
      .entry       (entry_w[i]),
      .gt          (gt_w[i]),
      .hit_out     (hit_w[i])
    );

    assign valid_vec[i] = entry_w[i].valid;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;

  // row operation; kept apart from the match result it produces
  always_comb begin
    cell_op = CELL_HOLD;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_INSERT: begin
              if ((occ < OCC_W'(CAPACITY)) && (arr_ctr != ARR_MAX)) begin
                cell_op = CELL_INSERT;
              end
            end
            CMD_REMOVE: cell_op = CELL_REMOVE;
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        // the ring waits only while a valid entry cannot be emitted
        if ((rot >= occ) || out_free) begin
          cell_op = CELL_ROTATE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next      = state;
    arr_ctr_next    = arr_ctr;
    occ_next        = occ;
    cnt_next        = cnt;
    rot_next        = rot;
    load            = 1'b0;
    res_status_next = STAT_OK;
    res_valid_next  = 1'b0;
    res_prio_next   = '0;
    res_pos_next    = '0;
    res_last_next   = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_INSERT: begin
              load = 1'b1;
              if (occ >= OCC_W'(CAPACITY)) begin
                res_status_next = STAT_FULL;
              end else if (arr_ctr == ARR_MAX) begin
                res_status_next = STAT_EXHAUSTED;
              end else begin
                arr_ctr_next   = arr_ctr + 1'b1;
                occ_next       = occ + 1'b1;
                res_valid_next = 1'b1;
                res_prio_next  = prio_ins;
                res_pos_next   = KEY_W'(arr_ctr + 1'b1);
                case (prio_ins)
                  PRIO_YELLOW: cnt_next[1] = cnt[1] + 1'b1;
                  PRIO_GREEN:  cnt_next[2] = cnt[2] + 1'b1;
                  default:     cnt_next[0] = cnt[0] + 1'b1;
                endcase
              end
            end
            CMD_REMOVE: begin
              load = 1'b1;
              if (hit_w[CAPACITY-1]) begin
                occ_next       = occ - 1'b1;
                res_valid_next = 1'b1;
                res_prio_next  = prio_req;
                res_pos_next   = key;
                case (prio_req)
                  PRIO_YELLOW: cnt_next[1] = cnt[1] - 1'b1;
                  PRIO_GREEN:  cnt_next[2] = cnt[2] - 1'b1;
                  default:     cnt_next[0] = cnt[0] - 1'b1;
                endcase
              end else begin
                res_status_next = STAT_NOT_FOUND;
              end
            end
            CMD_DUMP: begin
              if (occ == '0) begin
                load = 1'b1;   // single invalid beat
              end else begin
                state_next = S_DUMP;
                rot_next   = '0;
              end
            end
            default: ;         // unknown command: dropped, no beat
          endcase
        end
      end

      S_DUMP: begin
        // the head cell is emitted while the ring turns; after the last
        // valid entry the ring keeps turning until it is back in order
        if ((rot < occ) && !out_free) begin
          // ring holds while the output register is busy
        end else begin
          if (rot < occ) begin
            load           = 1'b1;
            res_valid_next = 1'b1;
            res_prio_next  = entry_w[0].prio;
            res_pos_next   = KEY_W'(entry_w[0].arr);
            res_last_next  = (rot + 1'b1 == occ);
          end
          if (rot == OCC_W'(CAPACITY - 1)) begin
            state_next = S_IDLE;
          end else begin
            rot_next = rot + 1'b1;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      arr_ctr <= '0;
      occ     <= '0;
      cnt     <= '{default: '0};
      rot     <= '0;
    end else begin
      state   <= state_next;
      arr_ctr <= arr_ctr_next;
      occ     <= occ_next;
      cnt     <= cnt_next;
      rot     <= rot_next;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: one beat parked while the next one is prepared
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_status <= res_status_next;
      res_valid  <= res_valid_next;
      res_prio   <= res_prio_next;
      res_pos    <= res_pos_next;
      res_last   <= res_last_next;
      // counts are reported modulo 32
      res_cnt[0] <= CNT_OUT_W'(cnt_next[0]);
      res_cnt[1] <= CNT_OUT_W'(cnt_next[1]);
      res_cnt[2] <= CNT_OUT_W'(cnt_next[2]);
    end
  end

  assign m_tdata = {5'b0, res_cnt[2], res_cnt[1], res_cnt[0], res_pos, res_prio, res_status};
  assign m_tuser = res_valid;
  assign m_tlast = res_last;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `TLPQ_ASSERT(a_occ_sum, 1'b1, occ == OCC_W'(cnt[0] + cnt[1] + cnt[2]), "occupancy != sum of counts")
  `TLPQ_ASSERT(a_row_packed, state == S_IDLE, (((CAPACITY'(valid_vec + 1'b1)) & valid_vec) == '0) && (OCC_W'($countones(valid_vec)) == occ), "cell row not packed at head")
  `TLPQ_ASSERT_NEXT(a_ins_grow, accept && (cmd == CMD_INSERT) && (occ < OCC_W'(CAPACITY)) && (arr_ctr != ARR_MAX), (occ == $past(occ) + 1'b1) && (arr_ctr == $past(arr_ctr) + 1'b1), "insert did not grow queue")

endmodule

// File: tb/three_level_priority_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_level_priority_queue_core_tb
// Drives insert, remove, dump and unknown command beats into the queue and
// checks every result beat against a behavioral copy of the queue. A short
// script covers reset, priorities, error codes and a full queue. Random
// traffic follows, then the queue is emptied and filled to capacity again.
// ----------------------------------------------------------------------------
module three_level_priority_queue_core_tb;
  import tlpq_pkg::*;

  localparam logic [1:0] CMD_UNKNOWN = 2'd3;  // decoded by nobody, must be dropped
  localparam logic [1:0] PRIO_NONE   = 2'd0;
  localparam int         RANDOM_CMDS = 250;
  localparam int         CYCLE_LIMIT = 200_000;
  localparam int         FAIL_CAP    = 20;

  typedef struct {
    logic [PRIO_W-1:0]       prio;
    logic [ARRIVAL_BITS-1:0] arr;
  } slot_t;

  typedef struct {
    status_t           status;
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [KEY_W-1:0]  pos;
    logic              last;
    logic [4:0]        n_red;
    logic [4:0]        n_yellow;
    logic [4:0]        n_green;
  } result_beat_t;

  // one script row; a typed row also states the single beat it must answer with
  typedef struct {
    logic [1:0]        cmd;
    logic [PRIO_W-1:0] prio;
    logic [KEY_W-1:0]  pos;
    int                reps;
    bit                typed;
    status_t           status;
    logic              valid;
    logic [PRIO_W-1:0] eprio;
    logic [KEY_W-1:0]  epos;
  } script_row_t;

  localparam int SCRIPT_LEN = 21;
  script_row_t script [SCRIPT_LEN] = '{
    '{CMD_DUMP,    PRIO_NONE,   16'h0000, 1,  1, STAT_OK,        0, PRIO_NONE,   16'd0},
    '{CMD_REMOVE,  PRIO_RED,    16'h0000, 1,  1, STAT_NOT_FOUND, 0, PRIO_NONE,   16'd0},
    '{CMD_REMOVE,  PRIO_NONE,   16'hFFFF, 1,  1, STAT_NOT_FOUND, 0, PRIO_NONE,   16'd0},
    '{CMD_INSERT,  PRIO_GREEN,  16'h0000, 1,  1, STAT_OK,        1, PRIO_GREEN,  16'd1},
    '{CMD_INSERT,  PRIO_RED,    16'hFFFF, 1,  1, STAT_OK,        1, PRIO_RED,    16'd2},
    '{CMD_INSERT,  PRIO_YELLOW, 16'h0000, 1,  1, STAT_OK,        1, PRIO_YELLOW, 16'd3},
    // priority zero saturates to red
    '{CMD_INSERT,  PRIO_NONE,   16'h0000, 1,  1, STAT_OK,        1, PRIO_RED,    16'd4},
    '{CMD_INSERT,  PRIO_RED,    16'h0000, 1,  0, STAT_OK,        0, PRIO_NONE,   16'd0},
    '{CMD_INSERT,  PRIO_GREEN,  16'h0000, 1,  0, STAT_OK,        0, PRIO_NONE,   16'd0},
    '{CMD_DUMP,    PRIO_NONE,   16'h0000, 1,  0, STAT_OK,        0, PRIO_NONE,   16'd0},
    // a remove with priority zero never matches, even on a live number
    '{CMD_REMOVE,  PRIO_NONE,   16'h0004, 1,  1, STAT_NOT_FOUND, 0, PRIO_NONE,   16'd0},
    '{CMD_REMOVE,  PRIO_YELLOW, 16'h0001, 1,  1, STAT_NOT_FOUND, 0, PRIO_NONE,   16'd0},
    '{CMD_REMOVE,  PRIO_RED,    16'h0004, 1,  1, STAT_OK,        1, PRIO_RED,    16'd4},
    '{CMD_UNKNOWN, PRIO_NONE,   16'h0000, 1,  0, STAT_OK,        0, PRIO_NONE,   16'd0},
    '{CMD_REMOVE,  PRIO_GREEN,  16'h0001, 1,  1, STAT_OK,        1, PRIO_GREEN,  16'd1},
    '{CMD_UNKNOWN, PRIO_GREEN,  16'hFFFF, 1,  0, STAT_OK,        0, PRIO_NONE,   16'd0},
    '{CMD_INSERT,  PRIO_YELLOW, 16'h0000, 12, 0, STAT_OK,        0, PRIO_NONE,   16'd0},
    '{CMD_INSERT,  PRIO_RED,    16'h0000, 1,  1, STAT_FULL,      0, PRIO_NONE,   16'd0},
    '{CMD_DUMP,    PRIO_NONE,   16'h0000, 1,  0, STAT_OK,        0, PRIO_NONE,   16'd0},
    '{CMD_REMOVE,  PRIO_YELLOW, 16'hFFFF, 1,  1, STAT_NOT_FOUND, 0, PRIO_NONE,   16'd0},
    '{CMD_REMOVE,  PRIO_YELLOW, 16'h0007, 1,  0, STAT_OK,        0, PRIO_NONE,   16'd0}
  };

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;   // command[1:0], priority_req[3:2], position[19:4]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // status[1:0], entry_priority[3:2],
                                     // entry_position[19:4], count_red[24:20],
                                     // count_yellow[29:25], count_green[34:30]
  logic                   m_tuser;   // entry_valid
  logic                   m_tlast;   // last

  // behavioral copy of the queue, kept in service order
  slot_t                   held [$];
  logic [ARRIVAL_BITS-1:0] arr_count;
  result_beat_t            due_beats [$];

  int  fail_count;
  int  cycle_count;
  bit  steady;   // both sides run without gaps while set

  three_level_priority_queue_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result beat carrying the per-priority counts of the queue as it stands
  function automatic result_beat_t make_beat(status_t st, logic v, logic [PRIO_W-1:0] p,
                                             logic [KEY_W-1:0] a, logic l);
    result_beat_t b;
    b.status   = st;
    b.valid    = v;
    b.prio     = p;
    b.pos      = a;
    b.last     = l;
    b.n_red    = '0;
    b.n_yellow = '0;
    b.n_green  = '0;
    foreach (held[i]) begin
      case (held[i].prio)
        PRIO_RED:    b.n_red++;
        PRIO_YELLOW: b.n_yellow++;
        PRIO_GREEN:  b.n_green++;
        default: ;
      endcase
    end
    return b;
  endfunction

  // applies one command to the queue copy and queues the beats it must produce
  task automatic run_queue_command(logic [1:0] cmd, logic [PRIO_W-1:0] prio,
                                   logic [KEY_W-1:0] pos);
    logic [PRIO_W-1:0] eff;
    int                at;
    bit                hit;
    eff = (prio == PRIO_NONE) ? PRIO_RED : prio;
    hit = 0;
    case (cmd)
      CMD_INSERT: begin
        // full wins over exhausted
        if (held.size() >= CAPACITY) begin
          due_beats.push_back(make_beat(STAT_FULL, 1'b0, PRIO_NONE, '0, 1'b1));
        end else if (arr_count == ARR_MAX) begin
          due_beats.push_back(make_beat(STAT_EXHAUSTED, 1'b0, PRIO_NONE, '0, 1'b1));
        end else begin
          arr_count++;
          at = held.size();
          foreach (held[i]) begin
            if (!hit && (held[i].prio > eff ||
                         (held[i].prio == eff && held[i].arr > arr_count))) begin
              at  = i;
              hit = 1;
            end
          end
          held.insert(at, '{prio: eff, arr: arr_count});
          due_beats.push_back(make_beat(STAT_OK, 1'b1, eff, arr_count[KEY_W-1:0], 1'b1));
        end
      end
      CMD_REMOVE: begin
        foreach (held[i]) begin
          if (!hit && held[i].prio == prio && held[i].arr == pos) begin
            at  = i;
            hit = 1;
          end
        end
        if (hit) begin
          held.delete(at);
          due_beats.push_back(make_beat(STAT_OK, 1'b1, prio, pos, 1'b1));
        end else begin
          due_beats.push_back(make_beat(STAT_NOT_FOUND, 1'b0, PRIO_NONE, '0, 1'b1));
        end
      end
      CMD_DUMP: begin
        if (held.size() == 0) begin
          due_beats.push_back(make_beat(STAT_OK, 1'b0, PRIO_NONE, '0, 1'b1));
        end else begin
          foreach (held[i]) begin
            due_beats.push_back(make_beat(STAT_OK, 1'b1, held[i].prio,
                                          held[i].arr[KEY_W-1:0], i == held.size() - 1));
          end
        end
      end
      default: ;  // unknown command: no beat
    endcase
  endtask

  // Puts a command on the bus after its gap and books its beats right away.
  // The beat stays up until taken and no result of it can appear before
  // then, so booking now equals booking at acceptance.
  task automatic offer_command(logic [1:0] cmd, logic [PRIO_W-1:0] prio,
                               logic [KEY_W-1:0] pos);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W-20){1'b0}}, pos, prio, cmd};
    run_queue_command(cmd, prio, pos);
  endtask

  task automatic wait_taken();
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_command(logic [1:0] cmd, logic [PRIO_W-1:0] prio,
                              logic [KEY_W-1:0] pos);
    offer_command(cmd, prio, pos);
    wait_taken();
  endtask

  task automatic drain_results();
    while (due_beats.size() != 0) @(posedge clk);
  endtask

  // result side: random stall per beat, none while steady
  initial begin
    int stall;
    m_tready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_beats.size() == 0) begin
        $error("result beat with nothing outstanding: tdata %h", m_tdata);
        fail_count++;
      end else begin
        want = due_beats.pop_front();
        check_field("status",         32'(want.status),   32'(m_tdata[1:0]));
        check_field("entry_valid",    32'(want.valid),    32'(m_tuser));
        check_field("entry_priority", 32'(want.prio),     32'(m_tdata[3:2]));
        check_field("entry_position", 32'(want.pos),      32'(m_tdata[19:4]));
        check_field("last",           32'(want.last),     32'(m_tlast));
        check_field("count_red",      32'(want.n_red),    32'(m_tdata[24:20]));
        check_field("count_yellow",   32'(want.n_yellow), 32'(m_tdata[29:25]));
        check_field("count_green",    32'(want.n_green),  32'(m_tdata[34:30]));
      end
    end
  end

  initial begin
    int          n_done;
    int          roll;
    int          idx;
    bit          filling;
    logic [1:0]  pick;
    script_row_t row;

    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    arr_count   = '0;
    fail_count  = 0;
    cycle_count = 0;
    steady      = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed script
    foreach (script[r]) begin
      row = script[r];
      repeat (row.reps) begin
        offer_command(row.cmd, row.prio, row.pos);
        if (row.typed) begin
          idx = due_beats.size() - 1;
          due_beats[idx].status = row.status;
          due_beats[idx].valid  = row.valid;
          due_beats[idx].prio   = row.eprio;
          due_beats[idx].pos    = row.epos;
        end
        wait_taken();
      end
    end

    // random traffic; fill and drain phases alternate so both full and
    // empty are reached, with gap-free stretches in between
    n_done = 0;
    while (n_done < RANDOM_CMDS && fail_count < FAIL_CAP) begin
      filling = ((n_done / 30) % 2) == 0;
      steady  = ((n_done / 45) % 4) == 3;
      roll    = $urandom_range(0, 99);
      if (roll < 5) begin
        send_command(CMD_UNKNOWN, PRIO_W'($urandom_range(0, 3)),
                     KEY_W'($urandom_range(0, 65535)));
        continue;
      end
      if (roll < 20) begin
        send_command(CMD_DUMP, PRIO_W'($urandom_range(0, 3)),
                     KEY_W'($urandom_range(0, 65535)));
      end else if (roll < 25) begin
        send_command(CMD_REMOVE, PRIO_W'($urandom_range(0, 3)),
                     KEY_W'($urandom_range(0, 65535)));
      end else if (roll < (filling ? 75 : 45) || held.size() == 0) begin
        pick = ($urandom_range(0, 9) == 0) ? PRIO_NONE : PRIO_W'($urandom_range(1, 3));
        send_command(CMD_INSERT, pick, KEY_W'($urandom_range(0, 65535)));
      end else begin
        idx = $urandom_range(0, held.size() - 1);
        send_command(CMD_REMOVE, held[idx].prio, held[idx].arr[KEY_W-1:0]);
      end
      n_done++;
      // hold off the sender until the output side has caught up
      if (n_done % 80 == 0) begin
        s_tvalid <= 1'b0;
        drain_results();
      end
    end

    // empty the queue
    steady = 0;
    while (held.size() != 0 && fail_count < FAIL_CAP) begin
      idx = $urandom_range(0, held.size() - 1);
      send_command(CMD_REMOVE, held[idx].prio, held[idx].arr[KEY_W-1:0]);
    end

    // fill to capacity, probe full, then free one slot and fill it again
    repeat (CAPACITY) send_command(CMD_INSERT, PRIO_W'($urandom_range(1, 3)), '0);
    send_command(CMD_INSERT, PRIO_GREEN, '0);      // full
    send_command(CMD_DUMP, PRIO_NONE, '0);
    idx = $urandom_range(0, held.size() - 1);
    send_command(CMD_REMOVE, held[idx].prio, held[idx].arr[KEY_W-1:0]);
    send_command(CMD_INSERT, PRIO_YELLOW, '0);     // takes the freed slot
    send_command(CMD_INSERT, PRIO_NONE, 16'hFFFF); // full again
    send_command(CMD_DUMP, PRIO_NONE, '0);

    s_tvalid <= 1'b0;
    drain_results();
    repeat (2 * CAPACITY) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
